// File: rtl/core/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// shared types and codes of the array list engine
// ----------------------------------------------------------------------------
package ale_pkg;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_FIND   = 3'd3,
        OP_ERASE  = 3'd4,
        OP_CLEAR  = 3'd5,
        OP_READ   = 3'd6,
        OP_NOP    = 3'd7
    } t_ale_op;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_BADPOS   = 3'd4
    } t_ale_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_READ
    } t_ale_state;

    typedef struct packed {
        t_ale_op            op;
        logic [5:0]         pos;
        logic signed [31:0] value;
    } t_ale_req;

endpackage

// File: rtl/core/ale_if.sv
// ----------------------------------------------------------------------------
// ale_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface ale_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [5:0]         position;
    logic signed [31:0] value;

    modport source (output valid, cmd, position, value, input ready);
    modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface ale_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;
    logic [6:0]         found_index;
    logic [6:0]         count;
    logic [2:0]         status;

    modport source (output valid, data, found_index, count, status, input ready);
    modport sink   (input valid, data, found_index, count, status, output ready);
endinterface

// File: rtl/core/ale_front.sv
// ----------------------------------------------------------------------------
// ale_front
// accepts command items, decodes them and queues them for the back end
// ----------------------------------------------------------------------------
module ale_front
    import ale_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ale_cmd_if.sink   i_cmd,
    output logic      o_req_valid,
    output t_ale_req  o_req,
    input  logic      i_req_ready
);

    t_ale_req   r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_ale_req   dec;
    logic       push;
    logic       pop;

    always_comb begin
        dec.pos   = i_cmd.position;
        dec.value = i_cmd.value;
        dec.op    = t_ale_op'(i_cmd.cmd);
    end

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push        = i_cmd.valid & i_cmd.ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign pop         = o_req_valid & i_req_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/core/ale_back.sv
// ----------------------------------------------------------------------------
// ale_back
// carries out list commands on the entry memory and holds the result item
// ----------------------------------------------------------------------------
module ale_back
    import ale_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  t_ale_req  i_req,
    output logic      o_req_ready,
    ale_rsp_if.source o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 6;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    t_ale_state            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_wa, n_wa;
    logic [CW-1:0]         r_found, n_found;
    logic                  r_pend, n_pend;
    t_ale_op               r_op, n_op;
    logic [5:0]            r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_word, n_word;

    logic                  r_ov, n_ov;
    logic signed [31:0]    r_odata, n_odata;
    logic [6:0]            r_ofound, n_ofound;
    logic [6:0]            r_ocount, n_ocount;
    t_ale_status           r_ostat, n_ostat;

    logic                  we;
    logic [AW-1:0]         wa;
    logic [DATA_WIDTH-1:0] wd;
    logic                  re;
    logic [AW-1:0]         ra;
    logic [DATA_WIDTH-1:0] in_word;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         in_pos_x;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         idx_x;
    logic                  full;
    logic                  issue;

    assign in_word  = DATA_WIDTH'(i_req.value);
    assign cnt_x    = XW'(r_count);
    assign in_pos_x = XW'(i_req.pos);
    assign pos_x    = XW'(r_pos);
    assign idx_x    = XW'(r_idx);
    assign full     = (r_count == CW'(CAPACITY));

    assign o_rsp.valid       = r_ov;
    assign o_rsp.data        = r_odata;
    assign o_rsp.found_index = r_ofound;
    assign o_rsp.count       = r_ocount;
    assign o_rsp.status      = r_ostat;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wa        = r_wa;
        n_found     = r_found;
        n_pend      = 1'b0;
        n_op        = r_op;
        n_pos       = r_pos;
        n_word      = r_word;
        n_ov        = r_ov & ~o_rsp.ready;
        n_odata     = r_odata;
        n_ofound    = r_ofound;
        n_ocount    = r_ocount;
        n_ostat     = r_ostat;
        we          = 1'b0;
        wa          = '0;
        wd          = r_word;
        re          = 1'b0;
        ra          = '0;
        issue       = 1'b0;
        o_req_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = ~r_ov;
                if (i_req_valid && !r_ov) begin
                    n_op     = i_req.op;
                    n_pos    = i_req.pos;
                    n_word   = in_word;
                    n_ov     = 1'b1;
                    n_odata  = '0;
                    n_ostat  = STAT_OK;
                    n_idx    = '0;
                    unique case (i_req.op)
                        OP_PUSH: begin
                            if (full) begin
                                n_ostat = STAT_FULL;
                            end else begin
                                we      = 1'b1;
                                wa      = AW'(r_count);
                                wd      = in_word;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_ostat = STAT_EMPTY;
                            end else begin
                                re      = 1'b1;
                                ra      = AW'(r_count - 1'b1);
                                n_count = r_count - 1'b1;
                                n_ov    = 1'b0;
                                n_state = S_READ;
                            end
                        end
                        OP_INSERT: begin
                            if (full) begin
                                n_ostat = STAT_FULL;
                            end else if (in_pos_x >= cnt_x) begin
                                n_ostat = STAT_BADPOS;
                            end else begin
                                n_idx   = r_count - 1'b1;
                                n_ov    = 1'b0;
                                n_state = S_SHIFT_UP;
                            end
                        end
                        OP_FIND, OP_ERASE: begin
                            n_ov    = 1'b0;
                            n_state = S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_READ: begin
                            if (in_pos_x >= cnt_x) begin
                                n_ostat = STAT_BADPOS;
                            end else begin
                                re      = 1'b1;
                                ra      = AW'(i_req.pos);
                                n_ov    = 1'b0;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_ofound = 7'(n_count);
                    n_ocount = 7'(n_count);
                end
            end
            S_READ: begin
                n_ov     = 1'b1;
                n_odata  = 32'($signed(r_rdata));
                n_ofound = 7'(r_count);
                n_ocount = 7'(r_count);
                n_ostat  = STAT_OK;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (r_pend && (r_rdata == r_word)) begin
                    if (r_op == OP_ERASE) begin
                        n_found = r_idx - 1'b1;
                        n_wa    = r_idx - 1'b1;
                        n_state = S_SHIFT_DN;
                    end else begin
                        n_ov     = 1'b1;
                        n_odata  = '0;
                        n_ofound = 7'(r_idx - 1'b1);
                        n_ocount = 7'(r_count);
                        n_ostat  = STAT_OK;
                        n_state  = S_IDLE;
                    end
                end else if (r_idx >= r_count) begin
                    n_ov     = 1'b1;
                    n_odata  = '0;
                    n_ofound = 7'(r_count);
                    n_ocount = 7'(r_count);
                    n_ostat  = STAT_NOTFOUND;
                    n_state  = S_IDLE;
                end else begin
                    re     = 1'b1;
                    ra     = AW'(r_idx);
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_SHIFT_DN: begin
                issue = (r_idx < r_count);
                if (issue) begin
                    re     = 1'b1;
                    ra     = AW'(r_idx);
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    we   = 1'b1;
                    wa   = AW'(r_wa);
                    wd   = r_rdata;
                    n_wa = r_wa + 1'b1;
                end
                if (!issue && !r_pend) begin
                    n_count  = r_count - 1'b1;
                    n_ov     = 1'b1;
                    n_odata  = '0;
                    n_ofound = 7'(r_found);
                    n_ocount = 7'(r_count - 1'b1);
                    n_ostat  = STAT_OK;
                    n_state  = S_IDLE;
                end
            end
            S_SHIFT_UP: begin
                issue = (idx_x > pos_x);
                if (issue) begin
                    re     = 1'b1;
                    ra     = AW'(r_idx);
                    n_idx  = r_idx - 1'b1;
                    n_wa   = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    we = 1'b1;
                    wa = AW'(r_wa);
                    wd = r_rdata;
                end
                if (!issue && !r_pend) begin
                    we       = 1'b1;
                    wa       = AW'(r_pos) + 1'b1;
                    wd       = r_word;
                    n_count  = r_count + 1'b1;
                    n_ov     = 1'b1;
                    n_odata  = '0;
                    n_ofound = 7'(r_count + 1'b1);
                    n_ocount = 7'(r_count + 1'b1);
                    n_ostat  = STAT_OK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= r_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wa     <= n_wa;
        r_found  <= n_found;
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_odata  <= n_odata;
        r_ofound <= n_ofound;
        r_ocount <= n_ocount;
        r_ostat  <= n_ostat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

endmodule

// File: rtl/core/array_list_engine_unit.sv
// ----------------------------------------------------------------------------
// array_list_engine_unit
// push, clear and commands rejected on count or position answer from idle, pop
// and read after one memory read, find walks, insert shifts up, erase walks
// then shifts down, with one memory read and at most one write per cycle
// throughput: one item at a time in the back end, taken the cycle after the
// previous result leaves, two items queued in front
// reset clears count and control, entry memory is not cleared
// ----------------------------------------------------------------------------
module array_list_engine_unit
    import ale_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ale_cmd_if.sink   i_cmd,
    ale_rsp_if.source o_rsp
);

    logic     req_valid;
    logic     req_ready;
    t_ale_req req;

    ale_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    ale_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_rsp       (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_found_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.found_index <= o_rsp.count))
        else $error("found index above count");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STAT_OK)) |-> (o_rsp.data == '0))
        else $error("data on failed command");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == STAT_FULL)) |-> (o_rsp.count == 7'(CAPACITY)))
        else $error("full status with free entries");
`endif

endmodule

// File: dv/ale_checker.sv
// ----------------------------------------------------------------------------
// ale_checker
// watches the command and result channels, keeps its own copy of the list,
// predicts one result per accepted command and compares it field by field
// ----------------------------------------------------------------------------
module ale_checker
    import ale_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ale_cmd_if.sink   i_cmd_mon,
    ale_rsp_if.sink   i_rsp_mon,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results_seen
);

    localparam int LIST_DEPTH = 64;

    typedef struct packed {
        logic signed [31:0] data;
        logic [6:0]         found_index;
        logic [6:0]         count;
        logic [2:0]         status;
    } t_list_rsp;

    logic signed [31:0] list_words [LIST_DEPTH];
    int                 list_len;
    t_list_rsp          expected_rsps [$];

    function automatic t_list_rsp apply_list_cmd(input logic [2:0] op_code,
                                                 input logic [5:0] pos,
                                                 input logic signed [31:0] word);
        t_list_rsp r;
        int        hit;
        hit      = -1;
        r        = '0;
        r.status = STAT_OK;
        case (t_ale_op'(op_code))
            OP_PUSH: begin
                if (list_len >= LIST_DEPTH) r.status = STAT_FULL;
                else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            OP_POP: begin
                if (list_len == 0) r.status = STAT_EMPTY;
                else begin
                    list_len--;
                    r.data = list_words[list_len];
                end
            end
            OP_INSERT: begin
                if (list_len >= LIST_DEPTH) r.status = STAT_FULL;
                else if (pos >= list_len) r.status = STAT_BADPOS;
                else begin
                    for (int i = list_len; i > pos + 1; i--) list_words[i] = list_words[i-1];
                    list_words[pos+1] = word;
                    list_len++;
                end
            end
            OP_FIND, OP_ERASE: begin
                for (int i = 0; i < list_len; i++)
                    if (hit < 0 && list_words[i] == word) hit = i;
                if (hit < 0) r.status = STAT_NOTFOUND;
                else if (t_ale_op'(op_code) == OP_ERASE) begin
                    for (int i = hit; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            OP_CLEAR: list_len = 0;
            OP_READ: begin
                if (pos >= list_len) r.status = STAT_BADPOS;
                else r.data = list_words[pos];
            end
            default: ;
        endcase
        r.count       = 7'(list_len);
        r.found_index = (hit >= 0 && hit <= list_len) ? 7'(hit) : 7'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_rsp want;
        t_list_rsp got;
        if (!i_rst_n) begin
            list_len       <= 0;
            o_fail_count   <= 0;
            o_results_seen <= 0;
            expected_rsps.delete();
        end else begin
            if (i_cmd_mon.valid && i_cmd_mon.ready)
                expected_rsps.push_back(apply_list_cmd(i_cmd_mon.cmd, i_cmd_mon.position,
                                                       i_cmd_mon.value));
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = {i_rsp_mon.data, i_rsp_mon.found_index, i_rsp_mon.count,
                       i_rsp_mon.status};
                o_results_seen <= o_results_seen + 1;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want !== got) begin
                        $display("%0t: mismatch data exp %0d act %0d, idx exp %0d act %0d",
                                 $realtime, want.data, got.data, want.found_index,
                                 got.found_index);
                        $display("%0t:   count exp %0d act %0d, status exp %0d act %0d",
                                 $realtime, want.count, got.count, want.status, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_rsps.size();

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives command items into the array list engine with random gaps and result
// stalls, including a long hold-off that fills the front queue, and reports
// the verdict from the checker's failure and pending counts
// ----------------------------------------------------------------------------
module tb;
    import ale_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   results_seen;
    bit   long_hold;
    int   list_guess;

    ale_cmd_if cmd_ch ();
    ale_rsp_if rsp_ch ();

    array_list_engine_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    ale_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_mon      (cmd_ch.sink),
        .i_rsp_mon      (rsp_ch.sink),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    // result side stalls
    initial begin
        int wait_cycles;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            wait_cycles = $urandom_range(3, 0);
            if (wait_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk iff rsp_ch.valid);
        end
    end

    task automatic send_item(input t_ale_op op_code, input logic [5:0] pos,
                             input logic signed [31:0] word, input bit do_gap);
        int gap;
        gap = do_gap ? $urandom_range(3, 0) : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= op_code;
        cmd_ch.position <= pos;
        cmd_ch.value    <= word;
        @(posedge i_clk iff cmd_ch.ready);
        case (op_code)
            OP_PUSH:   if (list_guess < 64) list_guess++;
            OP_POP:    if (list_guess > 0) list_guess--;
            OP_INSERT: if (list_guess < 64 && pos < list_guess) list_guess++;
            OP_CLEAR:  list_guess = 0;
            default: ;
        endcase
    endtask

    task automatic drain;
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_word;
        case ($urandom_range(3, 0))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return $urandom_range(7, 0) - 4;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int      sel;
        t_ale_op op_code;
        bit      grow;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.cmd      <= OP_NOP;
        cmd_ch.position <= '0;
        cmd_ch.value    <= '0;
        long_hold  = 1'b0;
        list_guess = 0;
        i_rst_n    <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, extremes, full store, every opcode
        send_item(OP_POP, 6'd0, 32'sd0, 1'b0);
        send_item(OP_READ, 6'd0, 32'sd0, 1'b0);
        send_item(OP_INSERT, 6'd0, 32'sd5, 1'b0);
        send_item(OP_FIND, 6'd0, 32'sd5, 1'b0);
        send_item(OP_ERASE, 6'd0, 32'sd5, 1'b0);
        send_item(OP_PUSH, 6'd0, 32'sh8000_0000, 1'b0);
        send_item(OP_PUSH, 6'd63, 32'sh7fff_ffff, 1'b0);
        send_item(OP_INSERT, 6'd0, -32'sd1, 1'b0);
        send_item(OP_INSERT, 6'd2, 32'sd1, 1'b0);
        send_item(OP_FIND, 6'd0, 32'sh7fff_ffff, 1'b0);
        send_item(OP_READ, 6'd63, 32'sd0, 1'b0);
        send_item(OP_READ, 6'd1, 32'sd0, 1'b0);
        send_item(OP_ERASE, 6'd0, -32'sd1, 1'b0);
        send_item(OP_NOP, 6'd63, -32'sd1, 1'b0);
        send_item(OP_POP, 6'd0, 32'sd0, 1'b0);
        send_item(OP_CLEAR, 6'd0, 32'sd0, 1'b0);
        // fill to capacity with the result side held off
        drain();
        long_hold = 1'b1;
        for (int i = 0; i < 64; i++) send_item(OP_PUSH, 6'(i), 32'(i * 3), 1'b0);
        send_item(OP_PUSH, 6'd0, 32'sd9, 1'b0);
        send_item(OP_INSERT, 6'd63, 32'sd9, 1'b0);
        send_item(OP_INSERT, 6'd0, 32'sd9, 1'b0);
        send_item(OP_READ, 6'd63, 32'sd0, 1'b0);
        send_item(OP_ERASE, 6'd0, 32'sd0, 1'b0);
        send_item(OP_INSERT, 6'd62, 32'sd7, 1'b0);
        send_item(OP_FIND, 6'd0, 32'sd189, 1'b0);
        drain();

        // random: mostly small lists, occasional trips to full
        for (int n = 0; n < 1000; n++) begin
            grow = (n % 250) > 120;
            sel  = $urandom_range(99, 0);
            if (sel < (grow ? 45 : 25))      op_code = OP_PUSH;
            else if (sel < (grow ? 50 : 38)) op_code = OP_POP;
            else if (sel < 55)               op_code = OP_INSERT;
            else if (sel < 70)               op_code = OP_FIND;
            else if (sel < 82)               op_code = OP_ERASE;
            else if (sel < (grow ? 82 : 84)) op_code = OP_CLEAR;
            else if (sel < 98)               op_code = OP_READ;
            else                             op_code = OP_NOP;
            send_item(op_code,
                      ($urandom_range(3, 0) == 0 || list_guess == 0) ? 6'($urandom)
                          : 6'($urandom_range(list_guess - 1, 0)),
                      pick_word(), (n % 100) > 20);
            if (n == 500) drain();
        end
        drain();
        repeat (200) @(posedge i_clk);

        $display("covered %0d results over push, pop, insert, find, erase, clear, read",
                 results_seen);
        $display("including empty and full stores, bad positions and misses");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
